@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons holds too.
`define SPQ_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define SPQ_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/spq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the sorted priority queue modules.
// ----------------------------------------------------------------------------
package spq_pkg;

	// Queue depth and the width of the entry counter (holds 0..CAPACITY)
	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;
	localparam int OCC_W    = 5;

	// Operation codes
	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	// Result status codes
	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_EMPTY = 2'd1,
		STATUS_FULL  = 2'd2
	} status_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;   // capture the request payload
		logic exec;   // apply the operation and load the result register
	} spq_ctl_t;

	// Datapath to top status
	typedef struct packed {
		logic full;
		logic empty;
	} spq_stat_t;

endpackage

@@ design/spq_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_req_if
// Request channel: one enqueue or dequeue operation per transfer.
// ----------------------------------------------------------------------------
interface spq_req_if;
	logic               valid;
	logic               ready;
	logic               cmd;
	logic signed [31:0] item_data;
	logic signed [31:0] item_priority;

	modport source (output valid, output cmd, output item_data, output item_priority,
		input ready);
	modport sink (input valid, input cmd, input item_data, input item_priority,
		output ready);
endinterface

@@ design/spq_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_rsp_if
// Response channel: one result per operation.
// ----------------------------------------------------------------------------
interface spq_rsp_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] popped_data;
	logic signed [31:0] head_data;
	logic               head_valid;
	logic [4:0]         occupancy;

	modport source (output valid, output status, output popped_data, output head_data,
		output head_valid, output occupancy, input ready);
	modport sink (input valid, input status, input popped_data, input head_data,
		input head_valid, input occupancy, output ready);
endinterface

@@ design/spq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl
// Handshake controller: captures a request, then applies it once the
// result register is free.
// ----------------------------------------------------------------------------
module spq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output spq_pkg::spq_ctl_t ctl
);
	import spq_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q, state_nxt;
	logic   rsp_valid_q;
	logic   rsp_free;

	// Result slot can take a new result when empty or being drained
	assign rsp_free = !rsp_valid_q || rsp_ready;

	// Next state and commands
	always_comb begin
		state_nxt = state_q;
		req_ready = 1'b0;
		ctl       = '0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					ctl.load  = 1'b1;
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (rsp_free) begin
					ctl.exec  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctl.exec) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

@@ design/spq_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_datapath
// Sorted cell array with per-cell compare-and-shift, entry counter and
// result register.
// ----------------------------------------------------------------------------
module spq_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  spq_pkg::spq_ctl_t  ctl,
	output spq_pkg::spq_stat_t stat,
	input  logic               req_cmd,
	input  logic signed [31:0] req_data,
	input  logic signed [31:0] req_prio,
	output logic [1:0]         rsp_status,
	output logic signed [31:0] rsp_popped,
	output logic signed [31:0] rsp_head,
	output logic               rsp_head_valid,
	output logic [4:0]         rsp_occupancy
);
	import spq_pkg::*;

	// Captured operation
	logic                     op_cmd_q;
	logic signed [DATA_W-1:0] op_data_q;
	logic signed [DATA_W-1:0] op_prio_q;

	// Cells, head at index 0; contents above the count are don't-care
	logic signed [DATA_W-1:0] cell_data_q [CAPACITY];
	logic signed [DATA_W-1:0] cell_prio_q [CAPACITY];
	logic [CNT_W-1:0]         count_q;

	// Per-cell compare and candidate next values
	logic [CAPACITY-1:0]      above;
	logic signed [DATA_W-1:0] enq_data [CAPACITY];
	logic signed [DATA_W-1:0] enq_prio [CAPACITY];
	logic signed [DATA_W-1:0] deq_data [CAPACITY];
	logic signed [DATA_W-1:0] deq_prio [CAPACITY];

	logic                     enq_ok, deq_ok;
	logic [CNT_W-1:0]         count_nxt;
	logic signed [DATA_W-1:0] head_nxt;
	status_t                  status_nxt;

	// Result register
	status_t                  res_status_q;
	logic signed [DATA_W-1:0] res_popped_q;
	logic signed [DATA_W-1:0] res_head_q;
	logic                     res_head_valid_q;
	logic [OCC_W-1:0]         res_occ_q;

	// Each cell: stay if strictly higher priority, else take new item or shift down
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign above[i] = (CNT_W'(i) < count_q) && (cell_prio_q[i] > op_prio_q);

		if (i == 0) begin : g_first
			assign enq_data[i] = above[i] ? cell_data_q[i] : op_data_q;
			assign enq_prio[i] = above[i] ? cell_prio_q[i] : op_prio_q;
		end else begin : g_rest
			assign enq_data[i] = above[i]   ? cell_data_q[i] :
			                     above[i-1] ? op_data_q      : cell_data_q[i-1];
			assign enq_prio[i] = above[i]   ? cell_prio_q[i] :
			                     above[i-1] ? op_prio_q      : cell_prio_q[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign deq_data[i] = cell_data_q[i];
			assign deq_prio[i] = cell_prio_q[i];
		end else begin : g_mid
			assign deq_data[i] = cell_data_q[i+1];
			assign deq_prio[i] = cell_prio_q[i+1];
		end
	end

	// Operation outcome
	always_comb begin
		enq_ok     = (op_cmd_q == CMD_ENQ) && (count_q != CNT_W'(CAPACITY));
		deq_ok     = (op_cmd_q == CMD_DEQ) && (count_q != '0);
		count_nxt  = count_q;
		head_nxt   = cell_data_q[0];
		status_nxt = STATUS_OK;
		if (enq_ok) begin
			count_nxt = count_q + CNT_W'(1);
			head_nxt  = enq_data[0];
		end else if (deq_ok) begin
			count_nxt = count_q - CNT_W'(1);
			head_nxt  = deq_data[0];
		end else if (op_cmd_q == CMD_ENQ) begin
			status_nxt = STATUS_FULL;
		end else begin
			status_nxt = STATUS_EMPTY;
		end
	end

	// Entry counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.exec) begin
			count_q <= count_nxt;
		end
	end

	// Operation capture, cell update and result register
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_cmd_q  <= req_cmd;
			op_data_q <= req_data;
			op_prio_q <= req_prio;
		end
		if (ctl.exec) begin
			for (int k = 0; k < CAPACITY; k++) begin
				if (enq_ok) begin
					cell_data_q[k] <= enq_data[k];
					cell_prio_q[k] <= enq_prio[k];
				end else if (deq_ok) begin
					cell_data_q[k] <= deq_data[k];
					cell_prio_q[k] <= deq_prio[k];
				end
			end
			res_status_q     <= status_nxt;
			res_popped_q     <= deq_ok ? cell_data_q[0] : '0;
			res_head_q       <= (count_nxt != '0) ? head_nxt : '0;
			res_head_valid_q <= (count_nxt != '0);
			res_occ_q        <= OCC_W'(count_nxt);
		end
	end

	assign stat.full  = (count_q == CNT_W'(CAPACITY));
	assign stat.empty = (count_q == '0);

	assign rsp_status     = res_status_q;
	assign rsp_popped     = res_popped_q;
	assign rsp_head       = res_head_q;
	assign rsp_head_valid = res_head_valid_q;
	assign rsp_occupancy  = res_occ_q;

endmodule

@@ design/sorted_priority_queue.sv @@
`timescale 1ns / 1ps
// Sorted priority queue of spq_pkg::CAPACITY entries (data and signed priority),
// kept in descending priority order in a row of compare-and-shift cells; among
// equal priorities the newest entry is served first. Each request (enqueue or
// dequeue) is first captured, then applied in a step in which every cell shifts
// in parallel, comparing against the new priority on an enqueue. A result holds
// in an output register until taken; the next request is accepted meanwhile, but
// its update waits until that register is free. Enqueue on a full queue, dequeue
// on an empty one, leave the contents unchanged and report full or empty status.
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Top level: controller, cell-array datapath and assertions.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_priority_queue (
	input logic       clk,
	input logic       arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);
	import spq_pkg::*;

	spq_ctl_t  ctl;
	spq_stat_t stat;

	// Handshake controller
	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.ctl       (ctl)
	);

	// Cell array and result register
	spq_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.stat           (stat),
		.req_cmd        (req.cmd),
		.req_data       (req.item_data),
		.req_prio       (req.item_priority),
		.rsp_status     (rsp.status),
		.rsp_popped     (rsp.popped_data),
		.rsp_head       (rsp.head_data),
		.rsp_head_valid (rsp.head_valid),
		.rsp_occupancy  (rsp.occupancy)
	);

	// One request at a time: no accept right after an accept
	`SPQ_ASSERT_NEXT(a_one_in_flight, req.valid && req.ready, !req.ready, "back-to-back accept")
	// Pending result's head_valid agrees with the live empty flag
	`SPQ_ASSERT_IMPL(a_head_matches, rsp.valid, rsp.head_valid == !stat.empty, "head_valid stale")
	// Full status only when the queue holds CAPACITY entries
	`SPQ_ASSERT_IMPL(a_full_occ, rsp.valid && rsp.status == STATUS_FULL, rsp.occupancy == OCC_W'(CAPACITY) && stat.full, "full status with room left")
	// Empty status only on an empty queue and with nothing popped
	`SPQ_ASSERT_IMPL(a_empty_pop, rsp.valid && rsp.status == STATUS_EMPTY, !rsp.head_valid && rsp.popped_data == '0, "empty status inconsistent")

endmodule
